// ----- hdl/binary_to_ascii_number_defines.svh -----
// Assertion helpers for the block's top-level file.
`ifndef BINARY_TO_ASCII_NUMBER_DEFINES_SVH
`define BINARY_TO_ASCII_NUMBER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define BTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define BTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bta_pkg.sv -----
package bta_pkg;

  localparam int FIELD_W      = 16;
  localparam int VALUE_W_DEF  = 16;
  localparam int CHAR_W       = 8;
  localparam int DIGIT_W      = 4;
  // a 16-bit field never needs more than five decimal digits
  localparam int DIGITS_MAX   = 5;
  // power of two, so the queue pointers wrap on their own
  localparam int QUEUE_DEPTH  = 2;

  localparam int RADIX_DEC    = 10;
  localparam int RADIX_HEX    = 16;

  // x / 10 == (x * 0xCCCD) >> 19, exact for every 16-bit x
  localparam logic [FIELD_W-1:0] DIV10_MUL = 16'hCCCD;
  localparam int                 DIV10_SHIFT = 19;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'd57;
  localparam logic [CHAR_W-1:0] ASCII_ALPHA = 8'd87;
  localparam logic [CHAR_W-1:0] ASCII_LC_A  = 8'd97;
  localparam logic [CHAR_W-1:0] ASCII_LC_F  = 8'd102;

  typedef enum logic {
    RADIX_DEC_E,
    RADIX_HEX_E
  } radix_e;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic               hex_mode;
  } bta_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ascii_char;
    logic              last;
  } bta_out_t;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    radix_e             radix;
  } job_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    c = CHAR_W'(d);
    if (d < DIGIT_W'(RADIX_DEC)) begin
      return c + ASCII_ZERO;
    end
    return c + ASCII_ALPHA;
  endfunction

endpackage

// ----- hdl/bta_front.sv -----
module bta_front #(
  parameter int VALUE_WIDTH = bta_pkg::VALUE_W_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  bta_pkg::bta_in_t in_data_i,
  output logic             in_stall_o,
  output logic             job_valid_o,
  output bta_pkg::job_t    job_o,
  input  logic             job_pop_i
);
  import bta_pkg::*;

  localparam int OP_W  = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [FIELD_W-1:0] OP_MASK = {FIELD_W{1'b1}} >> (FIELD_W - OP_W);

  job_t               mem_q [QUEUE_DEPTH];
  job_t               job_in;
  logic [PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PTR_W:0]     cnt_q, cnt_d;
  logic               full, push, pop;

  // classify: mask to operand width and pick the radix
  always_comb begin
    job_in.value = in_data_i.value & OP_MASK;
    job_in.radix = in_data_i.hex_mode ? RADIX_HEX_E : RADIX_DEC_E;
  end

  assign full        = (cnt_q == (PTR_W + 1)'(QUEUE_DEPTH));
  assign push        = in_valid_i && !full;
  assign pop         = job_pop_i && (cnt_q != '0);
  assign in_stall_o  = full;
  assign job_valid_o = (cnt_q != '0);
  assign job_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + PTR_W'(1) : wr_q;
    rd_d  = pop  ? rd_q + PTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + (PTR_W + 1)'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - (PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= job_in;
    end
  end

endmodule

// ----- hdl/bta_back.sv -----
module bta_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  bta_pkg::job_t     job_i,
  output logic              job_pop_o,
  output logic              out_valid_o,
  output bta_pkg::bta_out_t out_data_o,
  input  logic              out_stall_i
);
  import bta_pkg::*;

  localparam int IDX_W = $clog2(DIGITS_MAX);
  localparam int PROD_W = 2 * FIELD_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [FIELD_W-1:0] val_q, val_d;
  radix_e             radix_q, radix_d;
  logic [DIGIT_W-1:0] buf_q [DIGITS_MAX];
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  bta_out_t           out_q, out_d;

  logic [PROD_W-1:0]  prod;
  logic [FIELD_W-1:0] quo_dec, back_dec, rem_dec, quo;
  logic [DIGIT_W-1:0] digit;
  logic               slot_free, wr_digit;

  // one digit per cycle: reciprocal multiply for ten, shift for sixteen
  always_comb begin
    prod     = PROD_W'(val_q) * PROD_W'(DIV10_MUL);
    quo_dec  = FIELD_W'(prod >> DIV10_SHIFT);
    back_dec = (quo_dec << 3) + (quo_dec << 1);
    rem_dec  = val_q - back_dec;
    unique case (radix_q)
      RADIX_HEX_E: begin
        quo   = val_q >> DIGIT_W;
        digit = val_q[DIGIT_W-1:0];
      end
      default: begin
        quo   = quo_dec;
        digit = rem_dec[DIGIT_W-1:0];
      end
    endcase
  end

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    radix_d     = radix_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    job_pop_o   = 1'b0;
    wr_digit    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          val_d     = job_i.value;
          radix_d   = job_i.radix;
          cnt_d     = '0;
          state_d   = S_CONV;
        end
      end
      S_CONV: begin
        wr_digit = 1'b1;
        val_d    = quo;
        cnt_d    = cnt_q + IDX_W'(1);
        if (quo == '0 || cnt_q == IDX_W'(DIGITS_MAX - 1)) begin
          idx_d   = cnt_q;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_d      = 1'b1;
          out_d.ascii_char = digit_char(buf_q[idx_q]);
          out_d.last       = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q - IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    radix_q <= radix_d;
    cnt_q   <= cnt_d;
    idx_q   <= idx_d;
    out_q   <= out_d;
    if (wr_digit) begin
      buf_q[cnt_q] <= digit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hdl/binary_to_ascii_number.sv -----
// Converts an unsigned number to its ASCII digits, decimal or lower-case hex,
// most significant first, no leading zeros (zero gives a single '0'), with
// last set on the final beat. Each number is taken from the two-entry input
// queue, runs the digit loop (one divide-by-radix step per cycle, a reciprocal
// multiply for ten), then leaves as one beat per digit from the single output
// register, held there while the output is stalled; the next number is taken
// only once its last beat is in that register. Input is still accepted while
// the queue has room. VALUE_WIDTH below 16 masks off the upper value bits.
module binary_to_ascii_number #(
  parameter int VALUE_WIDTH = bta_pkg::VALUE_W_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  bta_pkg::bta_in_t  in_data_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  output bta_pkg::bta_out_t out_data_o,
  input  logic              out_stall_i
);
  import bta_pkg::*;

  `include "binary_to_ascii_number_defines.svh"

  logic job_valid, job_pop;
  job_t job;

  bta_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .job_valid_o(job_valid),
    .job_o      (job),
    .job_pop_i  (job_pop)
  );

  bta_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_i      (job),
    .job_pop_o  (job_pop),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

  `BTA_ASSERT(a_pop_needs_job, !job_pop || job_valid, "pop from empty queue")

  `BTA_ASSERT(a_char_is_digit, !out_valid_o ||
    (out_data_o.ascii_char >= ASCII_ZERO && out_data_o.ascii_char <= ASCII_NINE) ||
    (out_data_o.ascii_char >= ASCII_LC_A && out_data_o.ascii_char <= ASCII_LC_F),
    "output beat is not a digit character")

  // a run of digits leaves no gap between beats
  `BTA_ASSERT_NEXT(a_run_unbroken, out_valid_o && !out_stall_i && !out_data_o.last,
    out_valid_o, "gap inside a digit run")

endmodule

// ----- tb/tb_binary_to_ascii_number.sv -----
`timescale 1ns / 1ps

module tb_binary_to_ascii_number;
  import bta_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int RESET_CYC   = 8;
  localparam int RANDOM_NUMS = 286;
  localparam int CALM_TAIL   = 40;
  localparam int TAIL_CYC    = 30;
  localparam int STALL_LIMIT = 1000;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid    = 1'b0;
  bta_in_t  in_data     = '0;
  logic     in_stall_o;
  logic     out_valid_o;
  bta_out_t out_data_o;
  logic     out_stall   = 1'b0;

  bta_in_t  pending_numbers [$];
  bta_out_t expected_chars  [$];
  int       total_numbers   = 0;
  int       numbers_sent    = 0;
  int       mismatches      = 0;
  int       in_gap          = 0;
  int       out_gap         = 0;
  int       quiet_cycles    = 0;
  logic     calm;

  binary_to_ascii_number dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_data_i  (in_data),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // no new idle or stall bursts once the run is nearly through
  assign calm = (total_numbers > 0) && (numbers_sent >= total_numbers - CALM_TAIL);

  // digits of one number, most significant first, last flag on the final one
  task automatic predict_digits(input bta_in_t num);
    logic [CHAR_W-1:0] digits [$];
    bta_out_t          ch;
    int unsigned       v;
    int unsigned       radix;
    int unsigned       d;
    v     = 32'(num.value);
    radix = (num.hex_mode == RADIX_HEX_E) ? RADIX_HEX : RADIX_DEC;
    do begin
      d = v % radix;
      if (d < RADIX_DEC) begin
        digits.push_front(ASCII_ZERO + CHAR_W'(d));
      end else begin
        digits.push_front(ASCII_ALPHA + CHAR_W'(d));
      end
      v = v / radix;
    end while (v != 0);
    foreach (digits[i]) begin
      ch.ascii_char = digits[i];
      ch.last       = (i == digits.size() - 1);
      expected_chars.push_back(ch);
    end
  endtask

  function automatic void add_number(input int unsigned value, input logic hex);
    bta_in_t num;
    num.value    = FIELD_W'(value);
    num.hex_mode = hex;
    pending_numbers.push_back(num);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      in_gap   <= 0;
    end else begin
      if (in_valid && !in_stall_o) begin
        predict_digits(in_data);
        numbers_sent <= numbers_sent + 1;
      end
      if (in_valid && in_stall_o) begin
        // hold the beat
      end else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (pending_numbers.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        in_gap   <= $urandom_range(0, 13);
      end else begin
        in_valid <= 1'b1;
        in_data  <= pending_numbers.pop_front();
      end
    end
  end

  // output stall bursts, independent of out_valid
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      out_gap   <= 0;
    end else if (out_gap > 0) begin
      out_stall <= 1'b1;
      out_gap   <= out_gap - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      out_gap   <= $urandom_range(0, 13);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    bta_out_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual char %h last %b",
                 $time, out_data_o.ascii_char, out_data_o.last);
        mismatches <= mismatches + 1;
      end else begin
        want = expected_chars.pop_front();
        if (out_data_o.ascii_char !== want.ascii_char) begin
          $display("%0t: ascii_char mismatch, expected %h, actual %h",
                   $time, want.ascii_char, out_data_o.ascii_char);
          mismatches <= mismatches + 1;
        end else if (out_data_o.last !== want.last) begin
          $display("%0t: last mismatch, expected %b, actual %b",
                   $time, want.last, out_data_o.last);
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  // watchdog: cycles with no beat on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned bits;
    // zero, single digit edges, digit-count boundaries, full range
    add_number(0, RADIX_DEC_E);
    add_number(0, RADIX_HEX_E);
    add_number(1, RADIX_DEC_E);
    add_number(9, RADIX_DEC_E);
    add_number(10, RADIX_DEC_E);
    add_number(9, RADIX_HEX_E);
    add_number(10, RADIX_HEX_E);
    add_number(15, RADIX_HEX_E);
    add_number(16, RADIX_HEX_E);
    add_number(99, RADIX_DEC_E);
    add_number(100, RADIX_DEC_E);
    add_number(999, RADIX_DEC_E);
    add_number(1000, RADIX_DEC_E);
    add_number(9999, RADIX_DEC_E);
    add_number(10000, RADIX_DEC_E);
    add_number(32'h0000_ffff, RADIX_DEC_E);
    add_number(32'h0000_ffff, RADIX_HEX_E);
    add_number(32'h0000_0fff, RADIX_HEX_E);
    add_number(32'h0000_1000, RADIX_HEX_E);
    add_number(32'h0000_abcd, RADIX_HEX_E);
    add_number(32'h0000_8000, RADIX_DEC_E);
    add_number(32'h0000_7fff, RADIX_HEX_E);
    add_number(32'h0000_5555, RADIX_DEC_E);
    add_number(32'h0000_aaaa, RADIX_HEX_E);
    // random widths so every digit count shows up often
    repeat (RANDOM_NUMS) begin
      bits = $urandom_range(1, FIELD_W);
      add_number($urandom_range(0, (1 << bits) - 1), 1'($urandom_range(0, 1)));
    end
    total_numbers = pending_numbers.size();

    repeat (RESET_CYC) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_numbers.size() != 0 || in_valid || expected_chars.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYC) @(posedge clk_i);

    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/bta_pkg.sv
hdl/bta_front.sv
hdl/bta_back.sv
hdl/binary_to_ascii_number.sv
tb/tb_binary_to_ascii_number.sv
